@@ rtl/kmp_first_match_search_macros.svh @@
// Assertion macros shared by the checker of the KMP first-match search block.
// Depends on nothing; included by files that assert.
`ifndef KMP_FIRST_MATCH_SEARCH_MACROS_SVH
`define KMP_FIRST_MATCH_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KMP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/kmp_pkg.sv @@
// Shared types and codes of the KMP first-match search block.
// Depends on nothing; imported by the store, the top level and the checker.
package kmp_pkg;

	localparam int CH_BITS = 8;

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	typedef struct packed {
		logic p_we;
		logic f_we;
	} kmp_wr_t;

endpackage

@@ rtl/kmp_store.sv @@
// Pattern and failure-link memories, one write and one registered read port each.
// Depends on kmp_pkg.
module kmp_store #(
	parameter int AW = 6
) (
	input  logic                   clk,
	input  kmp_pkg::kmp_wr_t       wr,
	input  logic [AW-1:0]          p_waddr,
	input  logic [kmp_pkg::CH_BITS-1:0] p_wdata,
	input  logic [AW-1:0]          f_waddr,
	input  logic [AW-1:0]          f_wdata,
	input  logic [AW-1:0]          p_raddr,
	input  logic [AW-1:0]          f_raddr,
	output logic [kmp_pkg::CH_BITS-1:0] p_rdata,
	output logic [AW-1:0]          f_rdata
);
	import kmp_pkg::*;

	localparam int DEPTH = 1 << AW;

	logic [CH_BITS-1:0] p_mem [DEPTH];
	logic [AW-1:0]      f_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.p_we) begin
			p_mem[p_waddr] <= p_wdata;
		end
		p_rdata <= p_mem[p_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.f_we) begin
			f_mem[f_waddr] <= f_wdata;
		end
		f_rdata <= f_mem[f_raddr];
	end

endmodule

@@ rtl/kmp_out.sv @@
// Result output register with one pending slot behind it.
// Depends on nothing.
module kmp_out #(
	parameter int PW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic          push_found,
	input  logic [PW-1:0] push_pos,
	output logic          full,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          out_found,
	output logic [PW-1:0] out_pos
);

	logic          out_v_q;
	logic          out_found_q;
	logic [PW-1:0] out_pos_q;
	logic          pend_v_q;
	logic          pend_found_q;
	logic [PW-1:0] pend_pos_q;
	logic          advance;

	assign advance = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q  <= pend_v_q || push;
			pend_v_q <= pend_v_q && push;
		end else if (push) begin
			pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (pend_v_q) begin
				out_found_q  <= pend_found_q;
				out_pos_q    <= pend_pos_q;
				pend_found_q <= push_found;
				pend_pos_q   <= push_pos;
			end else begin
				out_found_q <= push_found;
				out_pos_q   <= push_pos;
			end
		end else if (push) begin
			pend_found_q <= push_found;
			pend_pos_q   <= push_pos;
		end
	end

	assign full      = pend_v_q;
	assign out_valid = out_v_q;
	assign out_found = out_found_q;
	assign out_pos   = out_pos_q;

endmodule

@@ rtl/kmp_first_match_search.sv @@
// Top level of the KMP first-match search block: control sequencer and failure-link walk.
// Depends on kmp_pkg, kmp_store and kmp_out.
//
// Input channel s_*: s_tuser selects a pattern byte or a text byte, s_tdata carries the
// byte and s_tlast marks the final byte of a pattern or of a text. Pattern bytes are
// written into the pattern memory as they arrive and the failure table grows with them.
// Output channel m_*: one transaction per text, m_tuser is set when a match was found
// and m_tdata holds its start position, or clear with zero data when the text ended
// without a match.
// Flow: the first byte of a pattern, a dropped pattern byte and a text byte after the
// match or against an empty pattern are taken without a walk. Any other byte enters the
// walk state, which follows failure links; each link is one read of the pattern and
// failure memories, whose read ports are registered. A result is registered in the
// output stage before it reaches m_tvalid.
// Reset leaves an empty pattern in loading mode; the memories are not cleared.
// When the receiver stalls, one result waits in the output register and one more in a
// pending slot; while that slot is occupied s_tready is held low.
module kmp_first_match_search #(
	parameter int PATTERN_MAX   = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [kmp_pkg::CH_BITS-1:0]          s_tdata,  // ch
	input  logic                                 s_tuser,  // op
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((POSITION_BITS+7)/8)*8-1:0]   m_tdata,  // position
	output logic                                 m_tuser   // found
);
	import kmp_pkg::*;

	localparam int AW = $clog2(PATTERN_MAX);
	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int PW = POSITION_BITS;
	localparam int DW = ((POSITION_BITS + 7) / 8) * 8;
	localparam int CW = ((PW > LW) ? PW : LW) + 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic          state_q;
	logic [LW-1:0] len_q;
	logic [AW-1:0] match_q;
	logic [PW-1:0] count_q;
	logic          done_q;
	logic          loading_q;
	logic [AW-1:0] last_fail_q;
	logic [AW-1:0] k_q;
	logic [CH_BITS-1:0] key_q;
	logic          mode_q;
	logic          tlast_q;

	logic          acc;
	logic          out_full;
	logic [LW-1:0] load_i;
	logic          load_full;
	logic          text_go;
	logic [AW-1:0] j_init;
	logic [AW-1:0] k_init;
	logic [AW-1:0] rd_addr;
	logic [CH_BITS-1:0] p_rdata;
	logic [AW-1:0] f_rdata;
	kmp_wr_t       wr;
	logic [AW-1:0] f_waddr;
	logic [AW-1:0] f_wdata;
	logic          eq;
	logic          walk_fin;
	logic [LW-1:0] kf;
	logic          full_m;
	logic          exact;
	logic          found_now;
	logic [AW-1:0] j_new;
	logic [PW-1:0] pos_calc;
	logic          push;
	logic          push_found;
	logic [PW-1:0] push_pos;
	logic [PW-1:0] out_pos;

	assign s_tready  = (state_q == ST_IDLE) && !out_full;
	assign acc       = s_tvalid && s_tready;
	assign load_i    = loading_q ? len_q : '0;
	assign load_full = load_i >= LW'(PATTERN_MAX);
	assign text_go   = !done_q && (len_q != '0);
	assign j_init    = (LW'(match_q) >= len_q) ? '0 : match_q;
	assign k_init    = (s_tuser == OP_TEXT) ? j_init : last_fail_q;
	assign rd_addr   = (state_q == ST_WALK) ? f_rdata : k_init;

	assign eq        = p_rdata == key_q;
	assign walk_fin  = (state_q == ST_WALK) && !((k_q != '0) && !eq);
	assign kf        = LW'(k_q) + LW'(eq);
	assign full_m    = kf >= len_q;
	assign exact     = count_q != '1;
	assign found_now = full_m && exact;
	assign j_new     = full_m ? (exact ? '0 : last_fail_q) : kf[AW-1:0];
	assign pos_calc  = PW'(CW'(count_q) + CW'(1) - CW'(len_q));

	always_comb begin
		wr.p_we = acc && (s_tuser == OP_PATTERN) && !load_full;
		wr.f_we = (wr.p_we && (load_i == '0)) || (walk_fin && (mode_q == OP_PATTERN));
		f_waddr = (state_q == ST_WALK) ? len_q[AW-1:0] : '0;
		f_wdata = (state_q == ST_WALK) ? kf[AW-1:0] : '0;
	end

	always_comb begin
		push       = 1'b0;
		push_found = 1'b0;
		push_pos   = '0;
		if (walk_fin && (mode_q == OP_TEXT)) begin
			push       = found_now || tlast_q;
			push_found = found_now;
			push_pos   = found_now ? pos_calc : '0;
		end else if (acc && (s_tuser == OP_TEXT) && !text_go && s_tlast) begin
			push = !done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			match_q     <= '0;
			count_q     <= '0;
			done_q      <= 1'b0;
			loading_q   <= 1'b1;
			last_fail_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc && (s_tuser == OP_PATTERN)) begin
						if (!loading_q) begin
							match_q <= '0;
							count_q <= '0;
							done_q  <= 1'b0;
						end
						loading_q <= !(s_tlast && (load_full || (load_i == '0)));
						if (!load_full) begin
							if (load_i == '0) begin
								last_fail_q <= '0;
								len_q       <= LW'(1);
							end else begin
								state_q <= ST_WALK;
							end
						end
					end else if (acc) begin
						loading_q <= 1'b0;
						if (text_go) begin
							state_q <= ST_WALK;
						end else if (s_tlast) begin
							match_q <= '0;
							count_q <= '0;
							done_q  <= 1'b0;
						end
					end
				end
				ST_WALK: begin
					if (walk_fin) begin
						state_q <= ST_IDLE;
						if (mode_q == OP_PATTERN) begin
							last_fail_q <= kf[AW-1:0];
							len_q       <= len_q + LW'(1);
							if (tlast_q) begin
								loading_q <= 1'b0;
							end
						end else if (tlast_q) begin
							match_q <= '0;
							count_q <= '0;
							done_q  <= 1'b0;
						end else begin
							match_q <= j_new;
							done_q  <= found_now;
							if (exact) begin
								count_q <= count_q + PW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK) begin
			k_q <= f_rdata;
		end else if (acc) begin
			k_q     <= k_init;
			key_q   <= s_tdata;
			mode_q  <= s_tuser;
			tlast_q <= s_tlast;
		end
	end

	kmp_store #(
		.AW(AW)
	) u_store (
		.clk    (clk),
		.wr     (wr),
		.p_waddr(load_i[AW-1:0]),
		.p_wdata(s_tdata),
		.f_waddr(f_waddr),
		.f_wdata(f_wdata),
		.p_raddr(rd_addr),
		.f_raddr(rd_addr - AW'(1)),
		.p_rdata(p_rdata),
		.f_rdata(f_rdata)
	);

	kmp_out #(
		.PW(PW)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_found(push_found),
		.push_pos  (push_pos),
		.full      (out_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_found (m_tuser),
		.out_pos   (out_pos)
	);

	assign m_tdata = DW'(out_pos);

endmodule

@@ rtl/kmp_sva.sv @@
// Port-level checker of the KMP first-match search block, bound to its top level.
// Depends on kmp_pkg and kmp_first_match_search_macros.svh.
`include "kmp_first_match_search_macros.svh"

module kmp_sva #(
	parameter int POSITION_BITS = 16
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic                                 s_tuser,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [((POSITION_BITS+7)/8)*8-1:0]   m_tdata,
	input logic                                 m_tuser
);
	import kmp_pkg::*;

	`KMP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	`KMP_ASSERT_NOW(a_notfound_zero, clk, arst_n, m_tvalid && !m_tuser,
		m_tdata == '0, "not-found result carries a nonzero position")

	`KMP_ASSERT_NEXT(a_pattern_silent, clk, arst_n,
		s_tvalid && s_tready && (s_tuser == OP_PATTERN) && !m_tvalid,
		!m_tvalid, "pattern transaction produced a result")

endmodule

bind kmp_first_match_search kmp_sva #(
	.POSITION_BITS(POSITION_BITS)
) u_kmp_sva (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

@@ bench/kmp_search_checker.sv @@
// Checker for the KMP first-match search block: watches both stream channels, predicts
// the result of each text from the accepted bytes and compares it with what the block
// delivers. Depends on kmp_pkg for the byte width and the pattern/text codes.
module kmp_search_checker #(
	parameter int PATTERN_MAX   = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic [kmp_pkg::CH_BITS-1:0]          s_tdata,  // ch
	input  logic                                 s_tuser,  // op
	input  logic                                 s_tlast,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic [((POSITION_BITS+7)/8)*8-1:0]   m_tdata,  // position
	input  logic                                 m_tuser,  // found
	output int unsigned                          mismatches,
	output int unsigned                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import kmp_pkg::*;

	localparam int POS_W    = ((POSITION_BITS + 7) / 8) * 8;
	localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);
	localparam logic [POSITION_BITS-1:0] COUNT_FULL = '1;

	typedef struct packed {
		logic                     found;
		logic [POSITION_BITS-1:0] position;
	} search_result_t;

	logic [CH_BITS-1:0]          pat_mem [PATTERN_MAX];
	logic [LEN_BITS-1:0]         border_len [PATTERN_MAX];
	int unsigned                 pat_len;
	int unsigned                 match_len;
	logic [POSITION_BITS-1:0]    text_idx;
	bit                          hit_seen;
	bit                          loading;
	search_result_t              awaited [$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	task automatic restart_search();
		match_len = 0;
		text_idx  = '0;
		hit_seen  = 0;
	endtask

	task automatic push_result(input logic found, input logic [POSITION_BITS-1:0] pos);
		search_result_t r;
		r.found    = found;
		r.position = pos;
		awaited.push_back(r);
	endtask

	task automatic predict_byte(input logic op, input logic [CH_BITS-1:0] ch,
			input logic last);
		int unsigned k;
		int unsigned j;
		if (op == OP_PATTERN) begin
			if (!loading) begin
				pat_len = 0;
				restart_search();
				loading = 1;
			end
			if (pat_len < PATTERN_MAX) begin
				pat_mem[pat_len] = ch;
				if (pat_len == 0) begin
					border_len[0] = '0;
				end else begin
					k = 32'(border_len[pat_len-1]);
					while (k > 0 && pat_mem[k] != ch)
						k = 32'(border_len[k-1]);
					if (pat_mem[k] == ch)
						k++;
					border_len[pat_len] = LEN_BITS'(k);
				end
				pat_len++;
			end
			if (last)
				loading = 0;
		end else begin
			loading = 0;
			if (!hit_seen && pat_len > 0) begin
				j = match_len;
				if (j >= pat_len)
					j = 0;
				while (j > 0 && pat_mem[j] != ch)
					j = 32'(border_len[j-1]);
				if (pat_mem[j] == ch)
					j++;
				if (j >= pat_len) begin
					// A match whose last byte came after the counter saturated has no start.
					if (text_idx != COUNT_FULL) begin
						push_result(1'b1, POSITION_BITS'(32'(text_idx) + 1 - pat_len));
						hit_seen = 1;
						j = 0;
					end else begin
						j = 32'(border_len[pat_len-1]);
					end
				end
				match_len = j;
				if (text_idx != COUNT_FULL)
					text_idx++;
			end
			if (last) begin
				if (!hit_seen)
					push_result(1'b0, '0);
				restart_search();
			end
		end
	endtask

	task automatic check_result(input logic found, input logic [POS_W-1:0] pos);
		search_result_t   want;
		logic [POS_W-1:0] want_pos;
		if (awaited.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with none expected: found=%0d position=%0d",
					$realtime, found, pos);
		end else begin
			want = awaited.pop_front();
			want_pos = '0;
			want_pos[POSITION_BITS-1:0] = want.position;
			if (found !== want.found || pos !== want_pos) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected found=%0d pos=%0d, got found=%0d pos=%0d",
						$realtime, want.found, want_pos, found, pos);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len = 0;
			loading = 1;
			restart_search();
			awaited.delete();
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tuser, m_tdata);
			if (s_tvalid && s_tready)
				predict_byte(s_tuser, s_tdata, s_tlast);
			outstanding = awaited.size();
		end
	end

endmodule

@@ bench/tb_kmp_first_match_search.sv @@
// Testbench top for the KMP first-match search block: clock, reset, byte stimulus with
// bursty sending and a stalling receiver, and the final verdict.
// Depends on kmp_pkg, the block itself and kmp_search_checker.
module tb_kmp_first_match_search;
	timeunit 1ns;
	timeprecision 1ps;

	import kmp_pkg::*;

	localparam int PATTERN_MAX   = 64;
	localparam int POSITION_BITS = 16;
	localparam int POS_W         = ((POSITION_BITS + 7) / 8) * 8;
	localparam int IDLE_LIMIT    = 3000;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_ITEMS  = 1250;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [CH_BITS-1:0] s_tdata;
	logic               s_tuser;
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [POS_W-1:0]   m_tdata;
	logic               m_tuser;

	int unsigned mismatches;
	int unsigned outstanding;

	int unsigned burst_left;
	int unsigned sent_count;
	int unsigned idle_cycles;
	bit          tx_steady;
	bit          rx_hold;
	int unsigned rx_mode;
	int unsigned rx_tick;
	logic [15:0] stall_pattern;

	logic [7:0]  pat_buf [$];
	logic [7:0]  word_buf [$];
	int unsigned alpha_base;
	int unsigned alpha_n;

	kmp_first_match_search #(
		.PATTERN_MAX  (PATTERN_MAX),
		.POSITION_BITS(POSITION_BITS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	kmp_search_checker #(
		.PATTERN_MAX  (PATTERN_MAX),
		.POSITION_BITS(POSITION_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// The receiver normally follows a randomly chosen mode; a hold request from the
	// stimulus keeps it stalled for a long stretch so that the block backs up.
	initial begin
		m_tready      = 1'b0;
		rx_mode       = 0;
		rx_tick       = 0;
		stall_pattern = 16'hffff;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold = 0;
			end else begin
				if (rx_tick % 200 == 0) begin
					rx_mode       = $urandom_range(3, 0);
					stall_pattern = 16'($urandom) | 16'h0001;
				end
				rx_tick++;
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(1, 0));
					2: m_tready <= ($urandom_range(3, 0) == 0);
					default: m_tready <= stall_pattern[rx_tick[3:0]];
				endcase
			end
		end
	end

	task automatic send_byte(input logic op, input logic [7:0] ch, input logic last);
		int unsigned gap;
		@(negedge clk);
		if (burst_left == 0) begin
			if (tx_steady)
				gap = 0;
			else if ($urandom_range(7, 0) == 0)
				gap = $urandom_range(25, 5);
			else
				gap = $urandom_range(4, 0);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(16, 1);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= ch;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		sent_count++;
	endtask

	task automatic send_str(input logic op, input string s, input bit with_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(op, s[i], with_last && i == s.len() - 1);
	endtask

	task automatic send_word(input logic op, input bit with_last);
		for (int i = 0; i < word_buf.size(); i++)
			send_byte(op, word_buf[i], with_last && i == word_buf.size() - 1);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		wait (outstanding == 0);
		repeat (30) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		if (alpha_n == 0)
			c = 8'($urandom_range(255, 0));
		else
			c = 8'(alpha_base + $urandom_range(alpha_n - 1, 0));
		return c;
	endfunction

	task automatic fill_random(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			word_buf.push_back(pick_char());
	endtask

	initial begin
		int unsigned random_from;
		int unsigned round;
		int unsigned plen;
		int unsigned ntext;
		bit          pressure_done;
		logic [7:0]  c;

		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = OP_PATTERN;
		s_tlast    = 1'b0;
		burst_left = 0;
		sent_count = 0;
		tx_steady  = 0;
		rx_hold    = 0;
		alpha_base = 0;
		alpha_n    = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Text against the empty pattern left by reset.
		send_str(OP_TEXT, "qz", 1);
		// Match on the last byte, then a match followed by ignored bytes.
		send_str(OP_PATTERN, "ab", 1);
		send_str(OP_TEXT, "xxab", 1);
		send_str(OP_TEXT, "abzzab", 1);
		// A new pattern arriving in the middle of a text restarts the search.
		send_str(OP_TEXT, "aab", 0);
		send_str(OP_PATTERN, "aab", 1);
		send_str(OP_TEXT, "aaaab", 1);
		// A text byte ends a pattern load that had no last mark.
		send_byte(OP_PATTERN, "c", 0);
		send_byte(OP_TEXT, "c", 1);
		// Extreme byte values.
		send_byte(OP_PATTERN, 8'h00, 0);
		send_byte(OP_PATTERN, 8'hff, 1);
		send_byte(OP_TEXT, 8'hff, 0);
		send_byte(OP_TEXT, 8'h00, 0);
		send_byte(OP_TEXT, 8'h00, 0);
		send_byte(OP_TEXT, 8'hff, 1);
		// Pattern longer than the store; only the first bytes are kept.
		for (int i = 0; i < PATTERN_MAX + 6; i++) begin
			c = (i >= PATTERN_MAX) ? "z" : ((i % 5 == 4) ? "b" : "a");
			send_byte(OP_PATTERN, c, i == PATTERN_MAX + 5);
		end
		send_byte(OP_TEXT, "a", 0);
		for (int i = 0; i < PATTERN_MAX; i++)
			send_byte(OP_TEXT, (i % 5 == 4) ? "b" : "a", i == PATTERN_MAX - 1);
		pause_until_drained();

		random_from   = sent_count;
		round         = 0;
		pressure_done = 0;
		while (sent_count - random_from < RANDOM_ITEMS) begin
			round++;
			alpha_n    = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(4, 1);
			alpha_base = $urandom_range(255, 0);
			tx_steady  = ($urandom_range(4, 0) == 0);
			plen = ($urandom_range(11, 0) == 0) ? $urandom_range(PATTERN_MAX + 6, 30)
				: $urandom_range(6, 1);
			word_buf.delete();
			fill_random(plen);
			pat_buf = word_buf;
			send_word(OP_PATTERN, $urandom_range(9, 0) != 0);
			ntext = $urandom_range(5, 1);
			for (int t = 0; t < ntext; t++) begin
				word_buf.delete();
				fill_random($urandom_range(20, 0));
				if ($urandom_range(1, 0)) begin
					for (int i = 0; i < plen && i < PATTERN_MAX; i++)
						word_buf.push_back(pat_buf[i]);
					fill_random($urandom_range(10, 0));
				end else if (word_buf.size() == 0) begin
					fill_random(1);
				end
				send_word(OP_TEXT, $urandom_range(11, 0) != 0);
			end
			if (!pressure_done && round == 8) begin
				tx_steady = 1;
				rx_hold   = 1;
				for (int i = 0; i < 24; i++)
					send_byte(OP_TEXT, pick_char(), 1);
				pressure_done = 1;
			end
			if (round % 20 == 0)
				pause_until_drained();
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ kmp_first_match_search.f @@
+incdir+rtl
rtl/kmp_pkg.sv
rtl/kmp_store.sv
rtl/kmp_out.sv
rtl/kmp_first_match_search.sv
rtl/kmp_sva.sv
bench/kmp_search_checker.sv
bench/tb_kmp_first_match_search.sv
